/* sv/gets_pkg.sv */
package gets_pkg;

   // Widths of the fields and of the datapath.
   localparam int SampleW = 63;
   localparam int ScaleW  = 31;
   localparam int WordW   = 64;
   localparam int FreqW   = 32;
   localparam int JumpW   = 8;
   localparam int KindW   = 2;
   localparam int StepW   = 4;
   localparam int CountW  = 6;

   localparam logic [FreqW-1:0]  FreqReset = 32'd10000000;
   localparam logic [JumpW-1:0]  JumpReset = 8'd32;
   localparam logic [CountW-1:0] DivLast   = 6'd63;

   // Register indexes of the configuration port.
   localparam logic CsrTickFrequency  = 1'b0;
   localparam logic CsrMaxJumpSeconds = 1'b1;

   // Jump codes.
   localparam logic [KindW-1:0] KindNormal   = 2'd0;
   localparam logic [KindW-1:0] KindBackward = 2'd1;
   localparam logic [KindW-1:0] KindForward  = 2'd2;

   typedef logic [StepW-1:0] step_type;

   // Program addresses.
   localparam step_type StepIdle     = 4'd0;
   localparam step_type StepDelta    = 4'd1;
   localparam step_type StepClassify = 4'd2;
   localparam step_type StepElapsed  = 4'd3;
   localparam step_type StepDivQuot  = 4'd4;
   localparam step_type StepSaveQuot = 4'd5;
   localparam step_type StepMulLo    = 4'd6;
   localparam step_type StepMulHi    = 4'd7;
   localparam step_type StepMulRem   = 4'd8;
   localparam step_type StepDivFrac  = 4'd9;
   localparam step_type StepSum      = 4'd10;
   localparam step_type StepOutput   = 4'd11;

   // Datapath operation of one step.
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_DELTA    = 4'd1,
      OP_CLASSIFY = 4'd2,
      OP_ELAPSED  = 4'd3,
      OP_DIV_STEP = 4'd4,
      OP_SAVE_Q   = 4'd5,
      OP_MUL_LO   = 4'd6,
      OP_MUL_HI   = 4'd7,
      OP_MUL_REM  = 4'd8,
      OP_SUM      = 4'd9,
      OP_OUTPUT   = 4'd10
   } op_type;

   // Sequencing of one step.
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,  // go on to the following step
      COND_WAIT_REQ = 3'd1,  // hold until an input transfer
      COND_LOOP     = 3'd2,  // repeat while the bit counter is not zero
      COND_WAIT_OUT = 3'd3,  // hold while the output register is full and rsp_tready is low
      COND_JUMP     = 3'd4   // always go to the target
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Control store.
   function automatic ctrl_word_type micro_word(input step_type step);
      ctrl_word_type w;
      unique case (step)
         StepIdle:     w = '{OP_NONE,     COND_WAIT_REQ, StepDelta};
         StepDelta:    w = '{OP_DELTA,    COND_NEXT,     StepClassify};
         StepClassify: w = '{OP_CLASSIFY, COND_NEXT,     StepElapsed};
         StepElapsed:  w = '{OP_ELAPSED,  COND_NEXT,     StepDivQuot};
         StepDivQuot:  w = '{OP_DIV_STEP, COND_LOOP,     StepDivQuot};
         StepSaveQuot: w = '{OP_SAVE_Q,   COND_NEXT,     StepMulLo};
         StepMulLo:    w = '{OP_MUL_LO,   COND_NEXT,     StepMulHi};
         StepMulHi:    w = '{OP_MUL_HI,   COND_NEXT,     StepMulRem};
         StepMulRem:   w = '{OP_MUL_REM,  COND_NEXT,     StepDivFrac};
         StepDivFrac:  w = '{OP_DIV_STEP, COND_LOOP,     StepDivFrac};
         StepSum:      w = '{OP_SUM,      COND_NEXT,     StepOutput};
         StepOutput:   w = '{OP_OUTPUT,   COND_WAIT_OUT, StepIdle};
         default:      w = '{OP_NONE,     COND_JUMP,     StepIdle};
      endcase
      return w;
   endfunction

endpackage

/* sv/guarded_elapsed_time_scaler.sv */
// Elapsed-time scaler with jump guard.
// The req channel carries one query: counter_sample in req_tdata[62:0] and
// scale in req_tdata[93:63]. The rsp channel returns one result per query:
// elapsed_scaled in rsp_tdata and jump_kind in rsp_tuser. The csr channel
// writes the tick frequency (index 0) and the jump limit in seconds (index 1);
// it is always ready and is meant to be used only while no query is in flight.
// A query runs through a microcode program of twelve steps, two of which
// loop once per bit of a 64-bit dividend over a one-bit restoring divider
// that is shared by the quotient and the fraction. A new query is taken in
// the cycle after the result has been loaded into the output register.
// The output register parts the channels: a waiting result does not block
// the next query from being taken, but if the receiver still stalls when the
// next result is ready, the program holds at its last step until rsp_tready.
// Reset is synchronous: it restores both registers to their defaults
// (10000000 ticks per second, 32 seconds), clears the last sample and the
// base, empties the output register and returns the program to its idle step.
module guarded_elapsed_time_scaler (
   input  logic        clock,
   input  logic        reset,
   // Query channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // counter_sample [62:0], scale [93:63]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // elapsed_scaled [63:0]
   output logic [1:0]  rsp_tuser,   // jump_kind [1:0]
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import gets_pkg::*;

   // Configuration and state.
   logic [FreqW-1:0]   freq_ff, freq_in;
   logic [JumpW-1:0]   jump_ff, jump_in;
   logic [WordW-1:0]   last_ff, last_in;
   logic [WordW-1:0]   base_ff, base_in;

   // Sequencer.
   step_type           step_ff, step_in;
   logic [CountW-1:0]  count_ff, count_in;

   // Datapath.
   logic [SampleW-1:0] sample_ff, sample_in;
   logic [ScaleW-1:0]  scale_ff, scale_in;
   logic [WordW-1:0]   delta_ff, delta_in;
   logic [39:0]        limit_ff, limit_in;
   logic [KindW-1:0]   kind_ff, kind_in;
   logic               neg_ff, neg_in;
   logic [WordW-1:0]   dvd_ff, dvd_in;
   logic [FreqW-1:0]   rem_ff, rem_in;
   logic [WordW-1:0]   quot_ff, quot_in;
   logic [WordW-1:0]   prod_ff, prod_in;
   logic [WordW-1:0]   sum_ff, sum_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic [WordW-1:0]   out_data_ff, out_data_in;
   logic [KindW-1:0]   out_kind_ff, out_kind_in;

   ctrl_word_type      ctrl;
   logic               req_fire;
   logic               out_busy;
   logic [FreqW-1:0]   freq_eff;
   logic [WordW-1:0]   elapsed;
   logic [FreqW:0]     shifted;
   logic               fits;
   logic [FreqW:0]     trial;
   logic [62:0]        mul_lo;
   logic [31:0]        mul_hi;
   logic [62:0]        mul_rem;

   assign ctrl       = micro_word(step_ff);
   assign req_tready = (step_ff == StepIdle);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = out_valid_ff && !rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   // A tick frequency of zero counts as one.
   assign freq_eff = (freq_ff == '0) ? FreqW'(1) : freq_ff;

   // One restoring division step: shift in the next dividend bit.
   assign shifted = {rem_ff, dvd_ff[WordW-1]};
   assign fits    = (shifted >= {1'b0, freq_eff});
   assign trial   = shifted - {1'b0, freq_eff};

   assign elapsed = {1'b0, sample_ff} - base_ff;
   assign mul_lo  = 63'(quot_ff[31:0]) * 63'(scale_ff);
   assign mul_hi  = quot_ff[63:32] * {1'b0, scale_ff};
   assign mul_rem = 63'(rem_ff) * 63'(scale_ff);

   // Sequencer and datapath next state.
   always_comb begin
      freq_in      = freq_ff;
      jump_in      = jump_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sample_in    = sample_ff;
      scale_in     = scale_ff;
      delta_in     = delta_ff;
      limit_in     = limit_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;

      // Register writes.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrTickFrequency:  freq_in = csr_data;
            CsrMaxJumpSeconds: jump_in = csr_data[JumpW-1:0];
            default:           freq_in = freq_ff;
         endcase
      end

      // The result leaves on its transfer.
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // Latch the query.
      if (req_fire) begin
         sample_in = req_tdata[SampleW-1:0];
         scale_in  = req_tdata[SampleW+ScaleW-1:SampleW];
      end

      // Datapath operation of the current step.
      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_DELTA: begin
            delta_in = {1'b0, sample_ff} - last_ff;
            limit_in = 40'(freq_eff) * 40'(jump_ff);
         end
         OP_CLASSIFY: begin
            last_in = {1'b0, sample_ff};
            if (delta_ff[WordW-1]) begin
               kind_in = KindBackward;
               base_in = base_ff + delta_ff;
            end else if (delta_ff > {24'd0, limit_ff}) begin
               kind_in = KindForward;
               base_in = base_ff + delta_ff;
            end else begin
               kind_in = KindNormal;
            end
         end
         OP_ELAPSED: begin
            // Divide the magnitude; the sign is put back at the end.
            neg_in   = elapsed[WordW-1];
            dvd_in   = elapsed[WordW-1] ? (~elapsed + WordW'(1)) : elapsed;
            rem_in   = '0;
            count_in = DivLast;
         end
         OP_DIV_STEP: begin
            dvd_in   = {dvd_ff[WordW-2:0], fits};
            rem_in   = fits ? trial[FreqW-1:0] : shifted[FreqW-1:0];
            count_in = count_ff - CountW'(1);
         end
         OP_SAVE_Q: begin
            quot_in = dvd_ff;
         end
         OP_MUL_LO: begin
            prod_in = {1'b0, mul_lo};
         end
         OP_MUL_HI: begin
            // Only the low half of the upper partial product survives the wrap.
            prod_in = prod_ff + {mul_hi, 32'd0};
         end
         OP_MUL_REM: begin
            dvd_in   = {1'b0, mul_rem};
            rem_in   = '0;
            count_in = DivLast;
         end
         OP_SUM: begin
            sum_in = prod_ff + dvd_ff;
         end
         OP_OUTPUT: begin
            if (!out_busy) begin
               out_valid_in = 1'b1;
               out_data_in  = neg_ff ? (~sum_ff + WordW'(1)) : sum_ff;
               out_kind_in  = kind_ff;
            end
         end
         default: begin
         end
      endcase

      // Next step.
      unique case (ctrl.cond)
         COND_NEXT:     step_in = step_ff + StepW'(1);
         COND_WAIT_REQ: step_in = req_fire ? ctrl.target : step_ff;
         COND_LOOP:     step_in = (count_ff != '0) ? ctrl.target : step_ff + StepW'(1);
         COND_WAIT_OUT: step_in = out_busy ? step_ff : ctrl.target;
         COND_JUMP:     step_in = ctrl.target;
         default:       step_in = StepIdle;
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= FreqReset;
         jump_ff      <= JumpReset;
         last_ff      <= '0;
         base_ff      <= '0;
         step_ff      <= StepIdle;
         out_valid_ff <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         jump_ff      <= jump_in;
         last_ff      <= last_in;
         base_ff      <= base_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      sample_ff   <= sample_in;
      scale_ff    <= scale_in;
      delta_ff    <= delta_in;
      limit_ff    <= limit_in;
      kind_ff     <= kind_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
   end

endmodule

/* sv/gets_checker.sv */
module gets_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser
);
   import gets_pkg::*;

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   else $error("result dropped while stalled");

   // The jump code is one of its three values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KindNormal || rsp_tuser == KindBackward ||
                      rsp_tuser == KindForward))
   else $error("invalid jump code");

   // The block is busy right after taking a query.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
   else $error("query taken while another is in flight");

   // No result appears in the cycle after a query transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
   else $error("result appeared too early");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
   else $error("result offered after reset");

endmodule

bind guarded_elapsed_time_scaler gets_checker u_gets_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser)
);

/* tb/guarded_elapsed_time_scaler_tb.sv */
module guarded_elapsed_time_scaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gets_pkg::*;

   localparam int          PhaseCount = 6;
   localparam int          PhaseItems = 305;
   localparam int          HoldCycles = 2000;
   localparam int          EndCycles  = 300;
   localparam int unsigned CycleLimit = 1_500_000;

   localparam logic [SampleW-1:0] TopSample = {SampleW{1'b1}};
   localparam logic [ScaleW-1:0]  TopScale  = {ScaleW{1'b1}};

   // One query as it travels in req_tdata: sample in the low bits, scale above.
   typedef struct packed {
      logic [ScaleW-1:0]  scale;
      logic [SampleW-1:0] sample;
   } query_type;

   typedef struct packed {
      logic [WordW-1:0] elapsed;
      logic [KindW-1:0] kind;
   } scaled_time_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CsrTickFrequency;
   logic [31:0] csr_data   = '0;

   // Local copy of the registers and of the timer state.
   logic [FreqW-1:0] cfg_tick_freq = FreqReset;
   logic [JumpW-1:0] cfg_max_jump  = JumpReset;
   logic [WordW-1:0] timer_last    = '0;
   logic [WordW-1:0] timer_base    = '0;

   query_type       pending_queries[$];
   scaled_time_type predicted_times[$];
   scaled_time_type oldest_time;
   logic [WordW-1:0] gen_last = '0;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic        rsp_hold  = 1'b0;
   logic        req_taken = 1'b0;
   int          mismatches = 0;
   int unsigned cycle_count = 0;

   logic [31:0] phase_freq  [PhaseCount] = '{32'd10000000, 32'd1000, 32'd1,
                                            32'hFFFFFFFF, 32'd37, 32'd0};
   logic [7:0]  phase_jump  [PhaseCount] = '{8'd32, 8'd5, 8'd1, 8'd255, 8'd0, 8'd128};
   int          phase_idle  [PhaseCount] = '{0, 76, 0, 9, 0, 76};
   int          phase_stall [PhaseCount] = '{0, 0, 76, 9, 0, 76};

   guarded_elapsed_time_scaler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10ns;
      clock = 1'b1;
      #10ns;
   end

   // Predict one query: guard the jump, then scale the elapsed ticks.
   function automatic scaled_time_type scale_query(input query_type q);
      logic [WordW-1:0]        current;
      logic [WordW-1:0]        delta_bits;
      logic signed [WordW-1:0] freq;
      logic signed [WordW-1:0] scl;
      logic signed [WordW-1:0] limit;
      logic signed [WordW-1:0] delta;
      logic signed [WordW-1:0] elapsed;
      logic signed [WordW-1:0] quot;
      logic signed [WordW-1:0] rem;
      logic signed [WordW-1:0] frac;
      scaled_time_type         r;
      current    = {1'b0, q.sample};
      freq       = (cfg_tick_freq == '0) ? 64'sd1 : $signed({32'd0, cfg_tick_freq});
      scl        = $signed({33'd0, q.scale});
      limit      = freq * $signed({56'd0, cfg_max_jump});
      delta_bits = current - timer_last;
      delta      = $signed(delta_bits);
      r.kind     = KindNormal;
      timer_last = current;
      if (delta < 0) begin
         r.kind     = KindBackward;
         timer_base = timer_base + delta_bits;
      end else if (delta > limit) begin
         r.kind     = KindForward;
         timer_base = timer_base + delta_bits;
      end
      // Signed division truncates toward zero; products and the sum wrap.
      elapsed   = $signed(current - timer_base);
      quot      = elapsed / freq;
      rem       = elapsed % freq;
      frac      = (rem * scl) / freq;
      r.elapsed = quot * scl + frac;
      return r;
   endfunction

   task automatic queue_query(input logic [SampleW-1:0] sample,
                              input logic [ScaleW-1:0] scale);
      pending_queries.push_back('{scale: scale, sample: sample});
      gen_last = {1'b0, sample};
   endtask

   // Mostly plausible counter progress, mixed with jumps and raw noise.
   task automatic queue_random(input int count);
      logic [WordW-1:0] limit;
      logic [WordW-1:0] noise;
      logic [WordW-1:0] nxt;
      logic [ScaleW-1:0] scale;
      int roll;
      for (int n = 0; n < count; n++) begin
         limit = ((cfg_tick_freq == '0) ? 64'd1 : {32'd0, cfg_tick_freq}) * cfg_max_jump;
         noise = {$urandom, $urandom};
         roll  = $urandom_range(99);
         if (roll < 70) begin
            nxt = gen_last + noise % (limit + 64'd1);
         end else if (roll < 78) begin
            nxt = gen_last + limit + $urandom_range(1);
         end else if (roll < 86) begin
            nxt = gen_last - noise % (gen_last + 64'd1);
         end else if (roll < 93) begin
            nxt = gen_last + limit + 64'd1 + (noise >> 14);
         end else begin
            nxt = noise >> 1;
         end
         if (nxt[WordW-1]) begin
            nxt = noise >> 1;
         end
         roll = $urandom_range(99);
         if (roll < 8) begin
            scale = '0;
         end else if (roll < 12) begin
            scale = 31'd1;
         end else if (roll < 16) begin
            scale = 31'd1000;
         end else if (roll < 20) begin
            scale = 31'd1000000;
         end else if (roll < 24) begin
            scale = TopScale;
         end else begin
            scale = ScaleW'($urandom);
         end
         queue_query(nxt[SampleW-1:0], scale);
      end
   endtask

   // Wait until every queued query has been taken and answered.
   task automatic drain();
      while (pending_queries.size() != 0 || req_tvalid || predicted_times.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (index == CsrTickFrequency) begin
         cfg_tick_freq = value;
      end else begin
         cfg_max_jump = value[JumpW-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Query driver: offers the next pending query once the current one is taken.
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (!reset && pending_queries.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            req_tdata  <= {2'b00, pending_queries.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus a long hold when asked.
   always @(negedge clock) begin
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Monitor: check each result transfer, then predict each query transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_times.size() == 0) begin
               $error("result transfer with no prediction waiting: elapsed_scaled %0d",
                      $signed(rsp_tdata));
               mismatches++;
            end else begin
               oldest_time = predicted_times.pop_front();
               if (rsp_tdata !== oldest_time.elapsed) begin
                  $error("elapsed_scaled: expected %0d, actual %0d",
                         $signed(oldest_time.elapsed), $signed(rsp_tdata));
                  mismatches++;
               end
               if (rsp_tuser !== oldest_time.kind) begin
                  $error("jump_kind: expected %0d, actual %0d", oldest_time.kind, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_times.push_back(scale_query(query_type'(req_tdata[SampleW+ScaleW-1:0])));
         end
      end
   end

   // Run limit.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: normal steps, the exact limit, both kinds of jump.
      queue_query('0, '0);
      queue_query(63'd10000000, 31'd1000);
      queue_query(63'd330000000, 31'd1000000);
      queue_query(63'd650000001, 31'd1000);
      queue_query(63'd5, 31'd1000);
      queue_query(TopSample, TopScale);
      queue_query(TopSample - 63'd20000000, 31'd7);
      queue_query(TopSample - 63'd5000000, TopScale);
      queue_query(TopSample - 63'd4999997, 31'd1);
      drain();

      // Zero tick frequency acts as one; a zero limit makes any forward step a jump.
      write_register(CsrTickFrequency, 32'd0);
      write_register(CsrMaxJumpSeconds, 32'd0);
      queue_query(gen_last[SampleW-1:0], 31'd1000);
      queue_query(gen_last[SampleW-1:0] + 63'd1, 31'd1000);
      queue_query(gen_last[SampleW-1:0] - 63'd3, 31'd1000000);
      drain();

      // Largest settings: the widest limit and the largest remainders.
      write_register(CsrTickFrequency, 32'hFFFFFFFF);
      write_register(CsrMaxJumpSeconds, 32'd255);
      queue_query('0, TopScale);
      queue_query(63'd1095216660225, TopScale);
      queue_query(63'd2190433320451, TopScale);
      queue_query(gen_last[SampleW-1:0] + 63'd12345, '0);
      queue_query(gen_last[SampleW-1:0] + 63'hFFFFFFFE, TopScale);
      drain();

      write_register(CsrTickFrequency, 32'd1);
      write_register(CsrMaxJumpSeconds, 32'd1);
      queue_query(gen_last[SampleW-1:0] + 63'd1, 31'd3);
      queue_query(gen_last[SampleW-1:0] + 63'd2, 31'd3);
      drain();

      // Random phases, each with its own settings and idle pattern.
      for (int p = 0; p < PhaseCount; p++) begin
         write_register(CsrTickFrequency, phase_freq[p]);
         write_register(CsrMaxJumpSeconds, {24'd0, phase_jump[p]});
         sender_idle_pct    = phase_idle[p];
         receiver_stall_pct = phase_stall[p];
         queue_random(PhaseItems);
         if (p == 4) begin
            // Hold the receiver off long enough for the input side to back up.
            fork
               begin
                  @(posedge clock);
                  rsp_hold = 1'b1;
                  repeat (HoldCycles) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         drain();
      end

      repeat (EndCycles) @(posedge clock);
      if (predicted_times.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_times.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/gets_pkg.sv
sv/guarded_elapsed_time_scaler.sv
sv/gets_checker.sv
tb/guarded_elapsed_time_scaler_tb.sv
